// ----- design/xtea_pkg.sv -----
// Shared constants, types and the round mixing function of the XTEA block cipher.
`timescale 1ns / 1ps

package xtea_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned NUM_KEYS   = 4;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [WORD_W-1:0]  XTEA_DELTA         = 32'h9E37_79B9;
  localparam logic [COUNT_W-1:0] CYCLE_COUNT_RESET  = 8'd32;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_COUNT = 3'd4;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef logic [NUM_KEYS-1:0][WORD_W-1:0] key_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic rounds_done;
  } dp_status_t;

  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] t;
    t = (x << 4) ^ (x >> 5);
    return t + x;
  endfunction

endpackage

// ----- design/xtea_datapath.sv -----
// Datapath of the XTEA cipher: block halves, running sums, round counter and result register.
`timescale 1ns / 1ps

module xtea_datapath (
  input  logic                                  clk,
  input  xtea_pkg::dp_cmd_t                     cmd,
  output xtea_pkg::dp_status_t                  sts,
  input  logic                                  command,
  input  logic [xtea_pkg::WORD_W-1:0]           word_low,
  input  logic [xtea_pkg::WORD_W-1:0]           word_high,
  input  xtea_pkg::key_t                        key_word,
  input  logic [xtea_pkg::COUNT_W-1:0]          cycle_count,
  output logic [xtea_pkg::WORD_W-1:0]           out_low,
  output logic [xtea_pkg::WORD_W-1:0]           out_high
);

  logic                            decrypt;
  logic [xtea_pkg::COUNT_W-1:0]    rounds_left;
  logic [xtea_pkg::WORD_W-1:0]     a;
  logic [xtea_pkg::WORD_W-1:0]     b;
  logic [xtea_pkg::WORD_W-1:0]     sum_lo;
  logic [xtea_pkg::WORD_W-1:0]     sum_hi;

  logic [xtea_pkg::COUNT_W-1:0]    count_dec;
  logic [xtea_pkg::WORD_W-1:0]     start_hi;
  logic [xtea_pkg::WORD_W-1:0]     start_lo;
  logic [xtea_pkg::WORD_W-1:0]     ksum_a;
  logic [xtea_pkg::WORD_W-1:0]     ksum_b;
  logic [xtea_pkg::WORD_W-1:0]     a_enc;
  logic [xtea_pkg::WORD_W-1:0]     b_enc;
  logic [xtea_pkg::WORD_W-1:0]     a_dec;
  logic [xtea_pkg::WORD_W-1:0]     b_dec;

  // The first half uses sum_lo and the second half sum_hi, which differ by one delta for any nonzero cycle count.
  always_comb begin
    count_dec = cycle_count - 8'd1;
    start_hi  = xtea_pkg::XTEA_DELTA * {24'd0, cycle_count};
    start_lo  = xtea_pkg::XTEA_DELTA * {24'd0, count_dec};
    ksum_a    = sum_lo + key_word[sum_lo[1:0]];
    ksum_b    = sum_hi + key_word[sum_hi[12:11]];
    a_enc     = a + (xtea_pkg::mix(b) ^ ksum_a);
    b_enc     = b + (xtea_pkg::mix(a_enc) ^ ksum_b);
    b_dec     = b - (xtea_pkg::mix(a) ^ ksum_b);
    a_dec     = a - (xtea_pkg::mix(b_dec) ^ ksum_a);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a           <= word_low;
      b           <= word_high;
      decrypt     <= command;
      rounds_left <= cycle_count;
      if (command == xtea_pkg::OP_DECRYPT) begin
        sum_lo <= start_lo;
        sum_hi <= start_hi;
      end else begin
        sum_lo <= '0;
        sum_hi <= xtea_pkg::XTEA_DELTA;
      end
    end else if (cmd.step) begin
      rounds_left <= rounds_left - 8'd1;
      if (decrypt == xtea_pkg::OP_DECRYPT) begin
        a      <= a_dec;
        b      <= b_dec;
        sum_lo <= sum_lo - xtea_pkg::XTEA_DELTA;
        sum_hi <= sum_hi - xtea_pkg::XTEA_DELTA;
      end else begin
        a      <= a_enc;
        b      <= b_enc;
        sum_lo <= sum_lo + xtea_pkg::XTEA_DELTA;
        sum_hi <= sum_hi + xtea_pkg::XTEA_DELTA;
      end
    end
    if (cmd.finish) begin
      out_low  <= a;
      out_high <= b;
    end
  end

  assign sts.rounds_done = (rounds_left == 8'd0);

endmodule

// ----- design/xtea_ctrl.sv -----
// Controller of the XTEA cipher: input handshake, round sequencing and output valid.
`timescale 1ns / 1ps

module xtea_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output xtea_pkg::dp_cmd_t     cmd,
  input  xtea_pkg::dp_status_t  sts
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;
  logic out_valid;
  logic out_valid_next;
  logic out_free;

  always_comb begin
    out_free       = !out_valid || m_tready;
    s_tready       = (state == ST_IDLE);
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && !m_tready;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!sts.rounds_done) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign m_tvalid = out_valid;

  a_finish_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!m_tvalid || m_tready))
    else $error("Result written while the previous one was still waiting.");

  a_finish_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> m_tvalid)
    else $error("Finished result did not raise the output valid.");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.step, cmd.finish}))
    else $error("Datapath received more than one command in a cycle.");

  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("Controller stayed ready after accepting a transaction.");

endmodule

// ----- design/xtea_block_cipher.sv -----
// Top level of the XTEA block cipher: configuration registers, controller and datapath.
`timescale 1ns / 1ps
//
// The slave stream carries one 64-bit block per transaction, with tuser selecting
// encryption (0) or decryption (1). The master stream returns the transformed block.
// Key words and the cycle count are written through the configuration port; the user
// must write them only while the block is idle, which the block itself does not enforce.
// A write takes effect at the clock edge where cfg_write_en is high, and indexes above
// the cycle count register are ignored. One XTEA cycle (both halves) is computed per
// clock by the round datapath until the cycle count is used up; the block then moves
// into the result register, from which it shows on the master side, and only then can a
// new block be accepted. A count of zero returns the block unchanged.
// The result register lets the next block be accepted and processed while the
// previous result waits; if the receiver stalls, the finished block is held in the
// datapath until the result register frees up, and no new block is accepted meanwhile.
// Reset clears the key words to zero, sets the cycle count to 32 and empties the
// pipeline. There is no clearing pass.

module xtea_block_cipher (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [63:0]                         s_tdata,   // word_low [31:0], word_high [63:32]
  input  logic                                s_tuser,   // command
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [63:0]                         m_tdata,   // out_low [31:0], out_high [63:32]
  input  logic                                cfg_write_en,
  input  logic [xtea_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [xtea_pkg::WORD_W-1:0]         cfg_data
);

  xtea_pkg::key_t                  key_word;
  logic [xtea_pkg::COUNT_W-1:0]    cycle_count;
  xtea_pkg::dp_cmd_t               cmd;
  xtea_pkg::dp_status_t            sts;
  logic [xtea_pkg::WORD_W-1:0]     out_low;
  logic [xtea_pkg::WORD_W-1:0]     out_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word    <= '0;
      cycle_count <= xtea_pkg::CYCLE_COUNT_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        xtea_pkg::REG_KEY_WORD0:   key_word[0] <= cfg_data;
        xtea_pkg::REG_KEY_WORD1:   key_word[1] <= cfg_data;
        xtea_pkg::REG_KEY_WORD2:   key_word[2] <= cfg_data;
        xtea_pkg::REG_KEY_WORD3:   key_word[3] <= cfg_data;
        xtea_pkg::REG_CYCLE_COUNT: cycle_count <= cfg_data[xtea_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  xtea_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  xtea_datapath u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .sts         (sts),
    .command     (s_tuser),
    .word_low    (s_tdata[31:0]),
    .word_high   (s_tdata[63:32]),
    .key_word    (key_word),
    .cycle_count (cycle_count),
    .out_low     (out_low),
    .out_high    (out_high)
  );

  assign m_tdata = {out_high, out_low};

endmodule

// ----- test/tb.sv -----
// Self-checking stream testbench for the XTEA block cipher with a built-in cipher model.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned TAIL_CYCLES = 300;
  localparam int unsigned MAX_WAIT    = 4;

  typedef struct packed {
    logic                        command;
    logic [xtea_pkg::WORD_W-1:0] word_high;
    logic [xtea_pkg::WORD_W-1:0] word_low;
  } block_t;

  typedef struct packed {
    logic [xtea_pkg::WORD_W-1:0] out_high;
    logic [xtea_pkg::WORD_W-1:0] out_low;
  } result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [63:0]                    s_tdata = '0;   // word_low [31:0], word_high [63:32]
  logic                           s_tuser = 1'b0; // command
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [63:0]                    m_tdata;        // out_low [31:0], out_high [63:32]
  logic                           cfg_write_en = 1'b0;
  logic [xtea_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [xtea_pkg::WORD_W-1:0]    cfg_data = '0;

  xtea_pkg::key_t               model_key = '0;
  logic [xtea_pkg::COUNT_W-1:0] model_count = xtea_pkg::CYCLE_COUNT_RESET;

  block_t  blocks_to_send[$];
  result_t cipher_results_due[$];
  block_t  block_on_bus;
  bit      idle_on = 1'b0;
  int      send_gap = 0;
  int      recv_stall = 0;
  int      error_count = 0;
  int      encrypt_count = 0;
  int      decrypt_count = 0;
  int      results_checked = 0;
  int      settings_used = 0;
  int      blocks_in_flight = 0;
  int unsigned cycle_total = 0;

  xtea_block_cipher i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5;
    clk = 1'b1;
    #5;
    clk = 1'b0;
  end

  function automatic logic [xtea_pkg::WORD_W-1:0] feistel_mix(
    input logic [xtea_pkg::WORD_W-1:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  function automatic result_t xtea_transform(input block_t blk);
    logic [xtea_pkg::WORD_W-1:0] v0;
    logic [xtea_pkg::WORD_W-1:0] v1;
    logic [xtea_pkg::WORD_W-1:0] total;
    result_t                     res;
    v0 = blk.word_low;
    v1 = blk.word_high;
    if (blk.command == xtea_pkg::OP_ENCRYPT) begin
      total = '0;
      for (int n = 0; n < model_count; n++) begin
        v0 = v0 + (feistel_mix(v1) ^ (total + model_key[total[1:0]]));
        total = total + xtea_pkg::XTEA_DELTA;
        v1 = v1 + (feistel_mix(v0) ^ (total + model_key[total[12:11]]));
      end
    end else begin
      total = xtea_pkg::XTEA_DELTA * {24'd0, model_count};
      for (int n = 0; n < model_count; n++) begin
        v1 = v1 - (feistel_mix(v0) ^ (total + model_key[total[12:11]]));
        total = total - xtea_pkg::XTEA_DELTA;
        v0 = v0 - (feistel_mix(v1) ^ (total + model_key[total[1:0]]));
      end
    end
    res.out_low  = v0;
    res.out_high = v1;
    return res;
  endfunction

  function automatic int draw_wait();
    return idle_on ? int'($urandom_range(0, MAX_WAIT)) : 0;
  endfunction

  always @(posedge clk) begin : driver
    block_t next_blk;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        cipher_results_due.push_back(xtea_transform(block_on_bus));
        if (block_on_bus.command == xtea_pkg::OP_ENCRYPT) encrypt_count++;
        else decrypt_count++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (blocks_to_send.size() > 0) begin
          next_blk = blocks_to_send.pop_front();
          block_on_bus <= next_blk;
          s_tvalid <= 1'b1;
          s_tdata <= {next_blk.word_high, next_blk.word_low};
          s_tuser <= next_blk.command;
          send_gap <= draw_wait();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    int      stall;
    if (rst) begin
      m_tready <= 1'b0;
      recv_stall <= 0;
    end else if (m_tvalid && m_tready) begin
      if (cipher_results_due.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got %h", $time, m_tdata);
        error_count++;
      end else begin
        want = cipher_results_due.pop_front();
        if (m_tdata[31:0] !== want.out_low) begin
          $display("%0t: out_low mismatch, expected %h, got %h",
                   $time, want.out_low, m_tdata[31:0]);
          error_count++;
        end
        if (m_tdata[63:32] !== want.out_high) begin
          $display("%0t: out_high mismatch, expected %h, got %h",
                   $time, want.out_high, m_tdata[63:32]);
          error_count++;
        end
        results_checked++;
        blocks_in_flight--;
      end
      stall = draw_wait();
      recv_stall <= stall;
      m_tready <= (stall == 0);
    end else if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      m_tready <= (recv_stall == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_total <= cycle_total + 1;
    if (cycle_total == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [xtea_pkg::CFG_IDX_W-1:0] idx,
                           input logic [xtea_pkg::WORD_W-1:0] value);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (idx < xtea_pkg::REG_CYCLE_COUNT) model_key[idx[1:0]] = value;
    else if (idx == xtea_pkg::REG_CYCLE_COUNT) model_count = value[xtea_pkg::COUNT_W-1:0];
  endtask

  // The upper bits of the count write carry random data that the block must drop.
  task automatic apply_setting(input xtea_pkg::key_t keys,
                               input logic [xtea_pkg::COUNT_W-1:0] count);
    logic [xtea_pkg::WORD_W-1:0] count_word;
    count_word = $urandom;
    count_word[xtea_pkg::COUNT_W-1:0] = count;
    write_reg(xtea_pkg::REG_KEY_WORD0, keys[0]);
    write_reg(xtea_pkg::REG_KEY_WORD1, keys[1]);
    write_reg(xtea_pkg::REG_KEY_WORD2, keys[2]);
    write_reg(xtea_pkg::REG_KEY_WORD3, keys[3]);
    write_reg(xtea_pkg::REG_CYCLE_COUNT, count_word);
    for (int idx = xtea_pkg::REG_CYCLE_COUNT + 1; idx < 2 ** xtea_pkg::CFG_IDX_W; idx++) begin
      write_reg(idx[xtea_pkg::CFG_IDX_W-1:0], $urandom);
    end
    settings_used++;
  endtask

  task automatic queue_block(input logic cmd, input logic [xtea_pkg::WORD_W-1:0] lo,
                             input logic [xtea_pkg::WORD_W-1:0] hi);
    block_t blk;
    blk.command = cmd;
    blk.word_low = lo;
    blk.word_high = hi;
    blocks_to_send.push_back(blk);
    blocks_in_flight++;
  endtask

  task automatic wait_drained();
    while (blocks_in_flight > 0) begin
      @(posedge clk);
    end
  endtask

  // Each encrypt block is followed, with even odds, by a decrypt of its ciphertext so that round trips are exercised.
  task automatic queue_random(input int n_items);
    block_t  blk;
    result_t ct;
    int      queued;
    queued = 0;
    while (queued < n_items) begin
      blk.command = 1'($urandom_range(0, 1));
      blk.word_low = $urandom;
      blk.word_high = $urandom;
      queue_block(blk.command, blk.word_low, blk.word_high);
      queued++;
      if ($urandom_range(0, 1) == 1 && blk.command == xtea_pkg::OP_ENCRYPT) begin
        ct = xtea_transform(blk);
        queue_block(xtea_pkg::OP_DECRYPT, ct.out_low, ct.out_high);
        queued++;
      end
    end
  endtask

  initial begin
    logic [xtea_pkg::WORD_W-1:0]  edge_words[5];
    logic [xtea_pkg::COUNT_W-1:0] counts[10];
    xtea_pkg::key_t               keys;
    int                           n_items;
    edge_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hAAAA_AAAA};
    counts = '{8'd32, 8'd1, 8'd255, 8'd7, 8'd0, 8'd64, 8'd2, 8'd16, 8'd33, 8'd32};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: zero key, cycle count of 32.
    for (int i = 0; i < 5; i++) begin
      queue_block(xtea_pkg::OP_ENCRYPT, edge_words[i], ~edge_words[(i + 2) % 5]);
      queue_block(xtea_pkg::OP_DECRYPT, edge_words[i], ~edge_words[(i + 2) % 5]);
    end
    wait_drained();

    // Zero cycles must pass the block through in both directions.
    apply_setting({4{32'hFFFF_FFFF}}, 8'd0);
    queue_block(xtea_pkg::OP_ENCRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_block(xtea_pkg::OP_DECRYPT, 32'h1234_5678, 32'h9ABC_DEF0);
    wait_drained();

    apply_setting({4{32'hFFFF_FFFF}}, 8'd1);
    queue_block(xtea_pkg::OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
    queue_block(xtea_pkg::OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();

    keys[0] = 32'hFFFF_FFFF;
    keys[1] = 32'h0000_0001;
    keys[2] = 32'h8000_0000;
    keys[3] = 32'h0000_0000;
    apply_setting(keys, 8'd255);
    queue_block(xtea_pkg::OP_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF);
    queue_block(xtea_pkg::OP_DECRYPT, 32'h0123_4567, 32'h89AB_CDEF);
    queue_block(xtea_pkg::OP_ENCRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      if (p == 0) begin
        keys = {4{32'hFFFF_FFFF}};
      end else begin
        for (int k = 0; k < xtea_pkg::NUM_KEYS; k++) keys[k] = $urandom;
      end
      apply_setting(keys, counts[p]);
      idle_on = (p % 2 == 0);
      n_items = (counts[p] > 8'd128) ? 40 : 120;
      queue_random(n_items);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (cipher_results_due.size() != 0) begin
      $display("%0t: results still outstanding, expected 0, got %0d",
               $time, cipher_results_due.size());
      error_count++;
    end

    $display("Sent %0d blocks (%0d encrypt, %0d decrypt) under %0d key and count settings.",
             encrypt_count + decrypt_count, encrypt_count, decrypt_count, settings_used + 1);
    $display("Compared %0d output blocks, %0d mismatches.", results_checked, error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/xtea_pkg.sv
design/xtea_datapath.sv
design/xtea_ctrl.sv
design/xtea_block_cipher.sv
test/tb.sv
